@@ src/imu_burst_frame_decoder_defines.svh @@
// Assertion macros shared by the decoder modules.
`ifndef IMU_BURST_FRAME_DECODER_DEFINES_SVH
`define IMU_BURST_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH
`define IBFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ibfd assertion failed");
`define IBFD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ibfd assertion failed");
`else
`define IBFD_ASSERT(label, prop)
`define IBFD_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ src/ibfd_pkg.sv @@
// Types and constants of the burst frame decoder.
`default_nettype none
package ibfd_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [5:0] LEN16 = 6'd22;
  localparam logic [5:0] LEN32 = 6'd34;
  localparam int         FRAME_MAX = 34;

  localparam logic signed [30:0] K_GYRO     = 31'sd7496132;
  localparam logic signed [30:0] K_ACCEL    = 31'sd52613349;
  localparam logic signed [30:0] K_TEMP     = 31'sd429496730;
  localparam logic signed [63:0] K_TEMP_OFS = 64'sd1173170316902;
  localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

  localparam logic [2:0] TEMP_STEP = 3'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] gyro_x;
    logic signed [47:0] gyro_y;
    logic signed [47:0] gyro_z;
    logic signed [47:0] accel_x;
    logic signed [47:0] accel_y;
    logic signed [47:0] accel_z;
    logic signed [47:0] temperature_k;
    logic [15:0]        sample_counter;
    logic [15:0]        status_word;
  } out_item_t;

  // Checked frame waiting to be scaled; raw values are sign extended in 16-bit mode.
  typedef struct packed {
    logic             wide;
    logic [5:0][31:0] raw;
    logic [15:0]      temp;
    logic [15:0]      counter;
  } frame_rec_t;

  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } frame_push_t;

endpackage
`default_nettype wire

@@ src/ibfd_front.sv @@
// Byte intake: frame indexing, checksum and status check, raw word assembly.
`default_nettype none
module ibfd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               burst_mode,
  input  wire logic               accept,
  input  wire ibfd_pkg::in_item_t item,
  output ibfd_pkg::frame_push_t   fpush
);
  import ibfd_pkg::*;

  logic [5:0]  byte_index;
  logic [15:0] byte_sum;
  logic [7:0]  frame_bytes [FRAME_MAX];

  logic [5:0]  n;
  logic [5:0]  idx_eff;
  logic [15:0] sum_eff;
  logic [15:0] sum_next;
  logic        active;
  logic        last;
  logic [15:0] check;
  logic [15:0] status;
  frame_rec_t  rec;

  always_comb begin
    n        = burst_mode ? LEN32 : LEN16;
    idx_eff  = item.frame_start ? 6'd0 : byte_index;
    sum_eff  = item.frame_start ? 16'd0 : byte_sum;
    active   = idx_eff < n;
    sum_next = sum_eff;
    if (idx_eff >= 6'd2 && idx_eff <= n - 6'd3) begin
      sum_next = sum_eff + {8'd0, item.rx_byte};
    end
    last   = active && (idx_eff == n - 6'd1);
    check  = {burst_mode ? frame_bytes[32] : frame_bytes[20], item.rx_byte};
    status = {frame_bytes[2], frame_bytes[3]};
  end

  always_comb begin
    rec.wide = burst_mode;
    for (int k = 0; k < 6; k++) begin
      if (burst_mode) begin
        rec.raw[k] = {frame_bytes[6 + 4 * k], frame_bytes[7 + 4 * k],
                      frame_bytes[4 + 4 * k], frame_bytes[5 + 4 * k]};
      end else begin
        rec.raw[k] = {{16{frame_bytes[4 + 2 * k][7]}},
                      frame_bytes[4 + 2 * k], frame_bytes[5 + 2 * k]};
      end
    end
    rec.temp    = burst_mode ? {frame_bytes[28], frame_bytes[29]}
                             : {frame_bytes[16], frame_bytes[17]};
    rec.counter = burst_mode ? {frame_bytes[30], frame_bytes[31]}
                             : {frame_bytes[18], frame_bytes[19]};
  end

  assign fpush.push = accept && last && (sum_eff == check) && (status == 16'd0);
  assign fpush.rec  = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 6'd0;
      byte_sum   <= 16'd0;
    end else if (accept) begin
      if (active) begin
        byte_index <= idx_eff + 6'd1;
        byte_sum   <= sum_next;
      end else begin
        byte_index <= idx_eff;
        byte_sum   <= sum_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      frame_bytes[idx_eff] <= item.rx_byte;
    end
  end

endmodule
`default_nettype wire

@@ src/ibfd_queue.sv @@
// Short FIFO of checked frames between intake and scaling.
`default_nettype none
`include "imu_burst_frame_decoder_defines.svh"
module ibfd_queue #(
  parameter int DEPTH = ibfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ibfd_pkg::frame_push_t fpush,
  input  wire logic                 pop,
  output ibfd_pkg::frame_rec_t      head,
  output logic                      q_valid,
  output logic                      full
);
  import ibfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_rec_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_FULL;
  assign q_valid = count != '0;
  assign do_push = fpush.push && !full;
  assign do_pop  = pop && q_valid;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= fpush.rec;
    end
  end

  `IBFD_ASSERT(a_no_push_when_full, fpush.push |-> !full)
  `IBFD_ASSERT(a_count_bound, count <= CNT_FULL)

endmodule
`default_nettype wire

@@ src/ibfd_back.sv @@
// Scaling sequencer: one shared multiplier, seven products per frame, output register.
`default_nettype none
`include "imu_burst_frame_decoder_defines.svh"
module ibfd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ibfd_pkg::frame_rec_t head,
  input  wire logic                 q_valid,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ibfd_pkg::out_item_t       out_data
);
  import ibfd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_FLUSH, S_OUT} state_t;

  state_t             state;
  logic [2:0]         step;
  logic signed [63:0] prod;
  logic [2:0]         prod_idx;
  logic               prod_valid;
  logic signed [47:0] work [7];

  logic signed [32:0] op_a;
  logic signed [30:0] op_b;
  logic signed [32:0] raw_ext;
  logic signed [63:0] rounded;
  logic signed [63:0] res;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == S_OUT) && out_free;

  always_comb begin
    raw_ext = '0;
    op_a    = '0;
    op_b    = K_GYRO;
    if (step == TEMP_STEP) begin
      op_a = {{17{head.temp[15]}}, head.temp};
      op_b = K_TEMP;
    end else begin
      raw_ext = {head.raw[step][31], head.raw[step]};
      op_a    = (step == 3'd2 || step == 3'd5) ? raw_ext : -raw_ext;
      op_b    = (step < 3'd3) ? K_GYRO : K_ACCEL;
    end
  end

  always_comb begin
    rounded = (prod + ROUND_HALF) >>> 16;
    if (prod_idx == TEMP_STEP) begin
      res = prod + K_TEMP_OFS;
    end else if (head.wide) begin
      res = rounded;
    end else begin
      res = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= 3'd0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= (state == S_CALC);
      out_valid  <= pop || (out_valid && out_stall);
      if (prod_valid) begin
        work[prod_idx] <= res[47:0];
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_CALC;
            step  <= 3'd0;
          end
        end
        S_CALC: begin
          prod     <= op_a * op_b;
          prod_idx <= step;
          if (step == TEMP_STEP) begin
            state <= S_FLUSH;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_FLUSH: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data.gyro_x         <= work[0];
            out_data.gyro_y         <= work[1];
            out_data.gyro_z         <= work[2];
            out_data.accel_x        <= work[3];
            out_data.accel_y        <= work[4];
            out_data.accel_z        <= work[5];
            out_data.temperature_k  <= work[6];
            out_data.sample_counter <= head.counter;
            out_data.status_word    <= 16'd0;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IBFD_ASSERT(a_busy_has_frame, (state != S_IDLE) |-> q_valid)
  `IBFD_ASSERT(a_pop_loads_out, pop |=> out_valid)
  `IBFD_ASSERT(a_flush_after_temp, (state == S_FLUSH) |-> (prod_valid && prod_idx == TEMP_STEP))

endmodule
`default_nettype wire

@@ src/imu_burst_frame_decoder.sv @@
// Top level of the inertial sensor burst frame decoder.
// Input channel: in_valid / in_stall / in_data, one reply byte per transaction,
//   with frame_start marking byte 0 of a frame.
// Output channel: out_valid / out_stall / out_data, one decoded sample per
//   frame whose checksum matches and whose status word is zero.
// cfg_we / cfg_wdata write burst_mode (0: 22-byte frame, 1: 34-byte frame);
//   write only while the block is idle.
// Throughput: one byte per cycle. in_stall rises only while the frame queue
//   (QUEUE_DEPTH entries) is full.
// After the last byte of a frame is accepted, the frame waits in the queue; the
//   shared multiplier then does seven products in turn, each registered and stored
//   (axis products rounded in 34-byte mode) in a work register, then the output register.
// Reset (rst, synchronous) clears the byte counter, checksum, queue and
//   output valid; burst_mode returns to 0.
// When out_stall holds, the result waits in the output register; later frames
//   collect in the queue, then bytes are stalled once it fills.
`default_nettype none
module imu_burst_frame_decoder #(
  parameter int QUEUE_DEPTH = ibfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ibfd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ibfd_pkg::out_item_t      out_data
);
  import ibfd_pkg::*;

  logic        burst_mode;
  logic        accept;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  frame_push_t fpush;
  frame_rec_t  head;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_mode <= 1'b0;
    end else if (cfg_we) begin
      burst_mode <= cfg_wdata;
    end
  end

  ibfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .burst_mode (burst_mode),
    .accept     (accept),
    .item       (in_data),
    .fpush      (fpush)
  );

  ibfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .fpush   (fpush),
    .pop     (pop),
    .head    (head),
    .q_valid (q_valid),
    .full    (q_full)
  );

  ibfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
